FILE: rtl/swlc_pkg.sv
// swlc_pkg: shared types, constants and helpers for the span word/line count unit
// no dependencies; imported by swlc_span_cnt and span_word_line_count_delta_unit
package swlc_pkg;

  localparam int COUNT_WIDTH = 31;
  localparam int DELTA_WIDTH = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [7:0]             byte_t;

  localparam count_t COUNT_MAX       = {COUNT_WIDTH{1'b1}};
  localparam byte_t  LINE_BREAK_INIT = 8'h0a;
  localparam byte_t  SPACE_CHAR      = 8'h20;
  localparam byte_t  TAB_CHAR        = 8'h09;

  typedef struct packed {
    byte_t data_byte;
    logic  is_last;
    byte_t left_char;
    logic  has_left;
    byte_t right_char;
    logic  has_right;
  } in_word_t;

  typedef struct packed {
    logic [30:0]                   line_breaks;
    logic signed [DELTA_WIDTH-1:0] word_delta;
  } out_word_t;

  function automatic logic is_sep(input byte_t b, input byte_t lb_char);
    is_sep = (b == lb_char) || (b == SPACE_CHAR) || (b == TAB_CHAR);
  endfunction

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

endpackage

FILE: rtl/span_word_line_count_delta_unit.sv
// span_word_line_count_delta_unit: top level, input register, result register, config
// depends on swlc_pkg and swlc_span_cnt
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_stall     in_word  (swlc_pkg::in_word_t)
//   out_     output     out_valid / out_stall   out_word (swlc_pkg::out_word_t)
//   cfg_     input      cfg_we                  cfg_wdata (line break byte)
//
// one byte accepted per cycle while in_stall is low; a byte is held in the input register,
// then updates the span counters, and a last byte loads its result into the result register
// rst_n is synchronous: counters clear, line break byte returns to 0x0a
// out_stall only holds back a last byte waiting for a full result register;
// ordinary bytes keep flowing while a result waits to be taken
module span_word_line_count_delta_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  swlc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output swlc_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  swlc_pkg::byte_t     cfg_wdata
);
  import swlc_pkg::*;

  // line break byte
  byte_t     lb_char_r;

  // input register stage
  logic      s1_valid_r;
  in_word_t  s1_word_r;

  // result register
  logic      out_valid_r;
  out_word_t out_r;

  out_word_t span_result;
  logic      out_take, s1_adv, s1_step, in_take;

  assign out_take = out_valid_r && !out_stall;
  // a last byte must find the result register free or emptying
  assign s1_adv   = !(s1_word_r.is_last && out_valid_r && out_stall);
  assign s1_step  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  swlc_span_cnt u_span_cnt (
    .clk    (clk),
    .rst_n  (rst_n),
    .lb_char(lb_char_r),
    .step   (s1_step),
    .item   (s1_word_r),
    .result (span_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_char_r <= LINE_BREAK_INIT;
    end else if (cfg_we) begin
      lb_char_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_step && s1_word_r.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1_word_r.is_last) begin
      out_r <= span_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // a last byte that advances always loads a result
  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_step && s1_word_r.is_last) |=> out_valid_r)
    else $error("last byte did not produce a result");

  // no result appears without a last byte behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !(s1_step && s1_word_r.is_last)) |=> !out_valid_r)
    else $error("result appeared without a last byte");

  // input only held back by a blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_word_r.is_last))
    else $error("input stalled without a blocked result");

  // word delta never drops below minus one
  a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.word_delta[DELTA_WIDTH-1] || (out_r.word_delta == '1)))
    else $error("word delta out of range");

endmodule

FILE: rtl/swlc_span_cnt.sv
// swlc_span_cnt: per-span state, line/word counters and boundary correction
// depends on swlc_pkg
module swlc_span_cnt (
  input  logic              clk,
  input  logic              rst_n,
  input  swlc_pkg::byte_t   lb_char,
  input  logic              step,
  input  swlc_pkg::in_word_t item,
  output swlc_pkg::out_word_t result
);
  import swlc_pkg::*;

  logic   at_start_r, prev_sep_r, first_sep_r, left_sep_r;
  count_t line_cnt_r, word_cnt_r;

  logic   sep, is_break, left_sep_now, right_sep, l, f, t, r;
  logic   merge, split;
  count_t line_cnt_nxt, word_cnt_nxt;
  logic signed [DELTA_WIDTH-1:0] delta;

  always_comb begin
    sep          = is_sep(item.data_byte, lb_char);
    is_break     = (item.data_byte == lb_char);
    left_sep_now = !item.has_left || is_sep(item.left_char, lb_char);
    right_sep    = !item.has_right || is_sep(item.right_char, lb_char);

    line_cnt_nxt = is_break ? sat_inc(line_cnt_r) : line_cnt_r;
    word_cnt_nxt = (!sep && prev_sep_r) ? sat_inc(word_cnt_r) : word_cnt_r;

    // first byte of a span supplies its own first/left flags
    l = at_start_r ? left_sep_now : left_sep_r;
    f = at_start_r ? sep : first_sep_r;
    t = sep;
    r = right_sep;

    merge = (l && !t && !r) || (r && !l && !f) || (!l && !f && !t && !r);
    split = !l && f && t && !r;

    if (merge) begin
      delta = DELTA_WIDTH'(word_cnt_nxt) - DELTA_WIDTH'(1);
    end else if (split) begin
      delta = DELTA_WIDTH'(sat_inc(word_cnt_nxt));
    end else begin
      delta = DELTA_WIDTH'(word_cnt_nxt);
    end

    result.line_breaks = line_cnt_nxt;
    result.word_delta  = delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.is_last)) begin
      at_start_r  <= 1'b1;
      prev_sep_r  <= 1'b1;
      first_sep_r <= 1'b0;
      left_sep_r  <= 1'b0;
      line_cnt_r  <= '0;
      word_cnt_r  <= '0;
    end else if (step) begin
      if (at_start_r) begin
        first_sep_r <= sep;
        left_sep_r  <= left_sep_now;
      end
      at_start_r <= 1'b0;
      prev_sep_r <= sep;
      line_cnt_r <= line_cnt_nxt;
      word_cnt_r <= word_cnt_nxt;
    end
  end

endmodule
